@@ src/iar_pkg.sv @@
// shared constants, types and helpers of the integer to ascii radix unit
package iar_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int BASE_W      = 6;
    localparam int REM_W       = BASE_W;
    localparam int ITER_W      = $clog2(VALUE_WIDTH);
    localparam int CHAR_W      = 8;
    localparam int SIGNED_W    = 32;

    localparam int IN_TDATA_W  = ((64 + BASE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((CHAR_W + CNT_W + 7) / 8) * 8;

    localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(36);
    localparam logic [BASE_W-1:0] BASE_DEC = BASE_W'(10);
    localparam logic [REM_W-1:0]  DIGIT_MAX = REM_W'(9);

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;

    localparam logic KIND_SIGNED   = 1'b0;
    localparam logic KIND_UNSIGNED = 1'b1;

    // result of one division by the radix
    typedef struct packed {
        logic                   done;
        logic [VALUE_WIDTH-1:0] quo;
        logic [REM_W-1:0]       rem;
    } t_div_res;

    // ascii code of one digit
    function automatic logic [CHAR_W-1:0] digit_char(input logic [REM_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        if (d > DIGIT_MAX) begin
            ch = CH_LOW_A + CHAR_W'(d) - CHAR_W'(DIGIT_MAX) - CHAR_W'(1);
        end else begin
            ch = CH_ZERO + CHAR_W'(d);
        end
        return ch;
    endfunction

endpackage

@@ src/iar_ram.sv @@
// generic simple dual port ram with registered read
module iar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/iar_div.sv @@
// bit-serial restoring divider of the value by a small radix
module iar_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [iar_pkg::VALUE_WIDTH-1:0] i_dividend,
    input  logic [iar_pkg::BASE_W-1:0]      i_divisor,
    output iar_pkg::t_div_res               o_res
);
    import iar_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [ITER_W-1:0]      r_iter;
    logic [VALUE_WIDTH-1:0] r_quo;
    logic [REM_W-1:0]       r_rem;
    logic [BASE_W-1:0]      r_div;

    logic [REM_W:0]         w_trial;
    logic                   w_ge;
    logic [REM_W:0]         w_diff;

    // one quotient bit per cycle: shift in the next dividend bit, compare, subtract
    assign w_trial = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_quo  <= {r_quo[VALUE_WIDTH-2:0], w_ge};
                r_rem  <= w_ge ? w_diff[REM_W-1:0] : w_trial[REM_W-1:0];
                r_iter <= r_iter + ITER_W'(1);
                if (r_iter == ITER_W'(VALUE_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.quo  = r_quo;
    assign o_res.rem  = r_rem;

endmodule

@@ src/integer_to_ascii_radix_unit.sv @@
// top level: converts one integer to its ascii digits in a radix from 2 to 36
// One request is taken at a time; s_axis_tready is high only while the unit is idle. Each
// digit costs one pass of the bit-serial divider, up to 64 digits per number (a single
// digit for zero). Then each character is read from the store in S_RD and S_RD_WAIT and
// held in S_SEND until m_axis_tready takes it (the sign goes from S_RD straight to S_SEND),
// sign first and most significant digit next, read back in reverse from the 64 x 8 digit
// store. tlast marks the final character and every character carries the total length of
// the number.
module integer_to_ascii_radix_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // value [63:0], base [69:64], zero fill above
    input  logic [iar_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // kind [0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // character [7:0], length [14:8], zero fill above
    output logic [iar_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);
    import iar_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RD,
        S_RD_WAIT,
        S_SEND
    } t_state;

    t_state                 r_state, n_state;
    logic                   r_div_start, n_div_start;
    logic [VALUE_WIDTH-1:0] r_quo, n_quo;
    logic [BASE_W-1:0]      r_base, n_base;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_neg, n_neg;
    logic [ADDR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]       r_k, n_k;
    logic [CNT_W-1:0]       r_len, n_len;
    logic [CHAR_W-1:0]      r_char, n_char;
    logic                   r_last, n_last;

    logic                   w_accept;
    logic [63:0]            w_value;
    logic [BASE_W-1:0]      w_base_raw;
    logic [BASE_W-1:0]      w_base_sat;
    logic [SIGNED_W-1:0]    w_pat;
    logic                   w_neg;
    logic [SIGNED_W-1:0]    w_mag;
    logic [VALUE_WIDTH-1:0] w_start_val;
    t_div_res               w_div;
    logic                   w_we;
    logic [CHAR_W-1:0]      w_rdata;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_value    = s_axis_tdata[63:0];
    assign w_base_raw = s_axis_tdata[64 +: BASE_W];

    // clamp the radix into its legal range
    always_comb begin
        if (w_base_raw < BASE_MIN) begin
            w_base_sat = BASE_MIN;
        end else if (w_base_raw > BASE_MAX) begin
            w_base_sat = BASE_MAX;
        end else begin
            w_base_sat = w_base_raw;
        end
    end

    // starting magnitude: sign only for negative signed values in decimal
    assign w_pat = w_value[SIGNED_W-1:0];
    assign w_neg = (s_axis_tuser == KIND_SIGNED) && w_pat[SIGNED_W-1] && (w_base_sat == BASE_DEC);
    assign w_mag = w_neg ? (~w_pat + SIGNED_W'(1)) : w_pat;
    assign w_start_val = (s_axis_tuser == KIND_UNSIGNED) ? w_value[VALUE_WIDTH-1:0]
                                                         : VALUE_WIDTH'(w_mag);

    iar_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_quo),
        .i_divisor  (r_base),
        .o_res      (w_div)
    );

    // digits are written least significant first as each division ends
    assign w_we = (r_state == S_DIV) && w_div.done;

    iar_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_cnt[ADDR_W-1:0]),
        .i_wdata (digit_char(w_div.rem)),
        .i_raddr (r_rd_ptr),
        .o_rdata (w_rdata)
    );

    // sequencer: divide repeatedly, then read the digits back in reverse
    always_comb begin
        n_state     = r_state;
        n_div_start = 1'b0;
        n_quo       = r_quo;
        n_base      = r_base;
        n_cnt       = r_cnt;
        n_neg       = r_neg;
        n_rd_ptr    = r_rd_ptr;
        n_k         = r_k;
        n_len       = r_len;
        n_char      = r_char;
        n_last      = r_last;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_quo       = w_start_val;
                    n_base      = w_base_sat;
                    n_neg       = w_neg;
                    n_cnt       = '0;
                    n_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div.done) begin
                    n_quo = w_div.quo;
                    n_cnt = r_cnt + CNT_W'(1);
                    if ((w_div.quo != '0) && (r_cnt != CNT_W'(STORE_DEPTH - 1))) begin
                        n_div_start = 1'b1;
                    end else begin
                        n_rd_ptr = r_cnt[ADDR_W-1:0];
                        n_len    = r_cnt + CNT_W'(1) + CNT_W'(r_neg);
                        n_k      = '0;
                        n_state  = S_RD;
                    end
                end
            end
            S_RD: begin
                if (r_neg && (r_k == '0)) begin
                    n_char  = CH_MINUS;
                    n_last  = (r_k == r_len - CNT_W'(1));
                    n_state = S_SEND;
                end else begin
                    n_state = S_RD_WAIT;
                end
            end
            S_RD_WAIT: begin
                n_char   = w_rdata;
                n_last   = (r_k == r_len - CNT_W'(1));
                n_rd_ptr = r_rd_ptr - ADDR_W'(1);
                n_state  = S_SEND;
            end
            S_SEND: begin
                if (m_axis_tready) begin
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + CNT_W'(1);
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_quo       <= '0;
            r_cnt       <= '0;
            r_neg       <= 1'b0;
            r_k         <= '0;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_start <= n_div_start;
            r_quo       <= n_quo;
            r_cnt       <= n_cnt;
            r_neg       <= n_neg;
            r_k         <= n_k;
            r_last      <= n_last;
        end
        r_base   <= n_base;
        r_rd_ptr <= n_rd_ptr;
        r_len    <= n_len;
        r_char   <= n_char;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_SEND);
    assign m_axis_tlast  = r_last;
    assign m_axis_tdata  = {{(OUT_TDATA_W - CHAR_W - CNT_W){1'b0}}, r_len, r_char};

    // a character waiting on the output blocks any new request
    a_no_overlap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request accepted while characters are pending");

    // a character taken without tlast means more characters follow
    a_more_follow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> !s_axis_tready)
        else $error("unit went idle before the final character");

    // the divider only finishes while the sequencer waits for it
    a_div_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == S_DIV))
        else $error("divider result arrived outside the division phase");

    // the digit count never passes the store depth
    a_cnt_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[ADDR_W] |-> (r_cnt[ADDR_W-1:0] == '0))
        else $error("digit count beyond store depth");

endmodule

@@ tb/tb_top.sv @@
// testbench of the integer to ascii radix unit: directed table, then random numbers
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import iar_pkg::*;

    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int RANDOM_ITEMS = 118;
    localparam int DRAIN_CYCLES = 200;
    localparam int ROW_COUNT    = 22;

    // one expected character of a converted number
    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
        logic [CNT_W-1:0]  length;
    } t_char_item;

    // one directed request; empty text means the predictor supplies the digits
    typedef struct {
        logic              kind;
        logic [63:0]       value;
        logic [BASE_W-1:0] base;
        string             text;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [IN_TDATA_W-1:0]  s_data  = '0;
    logic                   s_kind  = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_data;
    logic                   m_last;

    t_char_item pending_chars[$];
    bit         idle_free       = 1'b0;
    int         mismatch_count  = 0;
    int         numbers_sent    = 0;
    int         chars_checked   = 0;
    int         cycle_count     = 0;

    t_row directed_rows [ROW_COUNT] = '{
        '{KIND_SIGNED,   64'h0,                     6'd10, "0"},
        '{KIND_UNSIGNED, 64'h0,                     6'd2,  "0"},
        '{KIND_SIGNED,   64'h0000_0000_8000_0000,   6'd10, "-2147483648"},
        '{KIND_SIGNED,   64'h0000_0000_7fff_ffff,   6'd10, "2147483647"},
        '{KIND_SIGNED,   64'hffff_ffff_ffff_ffff,   6'd10, "-1"},
        '{KIND_SIGNED,   64'hffff_ffff_ffff_ffff,   6'd16, "ffffffff"},
        '{KIND_SIGNED,   64'h0000_0000_8000_0000,   6'd2,  ""},
        '{KIND_SIGNED,   64'h0000_0000_8000_0000,   6'd36, ""},
        '{KIND_SIGNED,   64'h0000_0000_ffff_ff01,   6'd16, "ffffff01"},
        '{KIND_SIGNED,   64'h0000_0000_ffff_fff6,   6'd10, "-10"},
        '{KIND_SIGNED,   64'hffff_ffff_0000_007b,   6'd10, "123"},
        '{KIND_UNSIGNED, 64'hffff_ffff_ffff_ffff,   6'd2,  ""},
        '{KIND_UNSIGNED, 64'hffff_ffff_ffff_ffff,   6'd16, "ffffffffffffffff"},
        '{KIND_UNSIGNED, 64'hffff_ffff_ffff_ffff,   6'd10, "18446744073709551615"},
        '{KIND_UNSIGNED, 64'hffff_ffff_ffff_ffff,   6'd36, ""},
        '{KIND_UNSIGNED, 64'h8000_0000_0000_0000,   6'd8,  ""},
        '{KIND_UNSIGNED, 64'd35,                    6'd36, "z"},
        '{KIND_UNSIGNED, 64'd10,                    6'd11, "a"},
        '{KIND_UNSIGNED, 64'd5,                     6'd0,  "101"},
        '{KIND_UNSIGNED, 64'd5,                     6'd1,  "101"},
        '{KIND_UNSIGNED, 64'd35,                    6'd37, "z"},
        '{KIND_UNSIGNED, 64'd36,                    6'd63, "10"}
    };

    integer_to_ascii_radix_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_kind),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tlast  (m_last)
    );

    // 100 MHz clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // digits of one number, most significant first, queued as expected characters
    task automatic predict_digits(input logic kind, input logic [63:0] value,
                                  input logic [BASE_W-1:0] base_in);
        logic [63:0]       radix;
        logic [63:0]       magnitude;
        logic [63:0]       remainder;
        logic              negative;
        logic [CHAR_W-1:0] digits [STORE_DEPTH];
        int                count;
        int                total;
        int                k;
        radix = 64'(base_in);
        // out-of-range radix saturates
        if (radix < 64'(BASE_MIN)) begin
            radix = 64'(BASE_MIN);
        end else if (radix > 64'(BASE_MAX)) begin
            radix = 64'(BASE_MAX);
        end
        // sign only for decimal; other radixes see the raw 32-bit pattern
        negative = 1'b0;
        if (kind == KIND_SIGNED) begin
            if (value[SIGNED_W-1] && radix == 64'(BASE_DEC)) begin
                negative  = 1'b1;
                magnitude = 64'h1_0000_0000 - {32'd0, value[SIGNED_W-1:0]};
            end else begin
                magnitude = {32'd0, value[SIGNED_W-1:0]};
            end
        end else begin
            magnitude = value;
        end
        // repeated division, least significant digit first
        count = 0;
        if (magnitude == 0) begin
            digits[0] = CH_ZERO;
            count = 1;
        end
        while (magnitude != 0) begin
            remainder = magnitude % radix;
            if (remainder > 64'(DIGIT_MAX)) begin
                digits[count] = CH_LOW_A + CHAR_W'(remainder - 64'd10);
            end else begin
                digits[count] = CH_ZERO + CHAR_W'(remainder);
            end
            magnitude = magnitude / radix;
            count++;
        end
        total = count + int'(negative);
        if (negative) begin
            pending_chars.push_back('{CH_MINUS, 1'b0, CNT_W'(total)});
        end
        for (k = count - 1; k >= 0; k--) begin
            pending_chars.push_back('{digits[k], k == 0, CNT_W'(total)});
        end
    endtask

    // expected characters typed in as text
    task automatic queue_text(input string text);
        int k;
        for (k = 0; k < text.len(); k++) begin
            pending_chars.push_back('{CHAR_W'(text[k]), k == text.len() - 1,
                                      CNT_W'(text.len())});
        end
    endtask

    // one request on the input stream, with a random gap ahead of it
    task automatic send_request(input logic kind, input logic [63:0] value,
                                input logic [BASE_W-1:0] base, input string text);
        int gap;
        gap = idle_free ? 0 : $urandom_range(0, 15);
        @(negedge i_clk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_data  <= IN_TDATA_W'({base, value});
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        if (text.len() == 0) begin
            predict_digits(kind, value, base);
        end else begin
            queue_text(text);
        end
        numbers_sent++;
    endtask

    // output side: random stalls, each character checked against the oldest expectation
    initial begin
        int         stall;
        t_char_item wanted;
        @(posedge i_rst_n);
        forever begin
            stall = idle_free ? 0 : $urandom_range(0, 15);
            @(negedge i_clk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_ready <= 1'b1;
            @(posedge i_clk);
            while (m_valid !== 1'b1) @(posedge i_clk);
            chars_checked++;
            if (pending_chars.size() == 0) begin
                $error("character %h arrived with nothing expected", m_data[CHAR_W-1:0]);
                mismatch_count++;
            end else begin
                wanted = pending_chars.pop_front();
                if (m_data[CHAR_W-1:0] !== wanted.character) begin
                    $error("character: expected %h, got %h", wanted.character,
                           m_data[CHAR_W-1:0]);
                    mismatch_count++;
                end
                if (m_last !== wanted.last) begin
                    $error("last: expected %b, got %b", wanted.last, m_last);
                    mismatch_count++;
                end
                if (m_data[CHAR_W +: CNT_W] !== wanted.length) begin
                    $error("length: expected %0d, got %0d", wanted.length,
                           m_data[CHAR_W +: CNT_W]);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus: reset, directed table, random numbers, drain
    initial begin
        logic              kind;
        logic [63:0]       value;
        logic [BASE_W-1:0] base;
        int                i;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < ROW_COUNT; i++) begin
            send_request(directed_rows[i].kind, directed_rows[i].value,
                         directed_rows[i].base, directed_rows[i].text);
        end

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            // hold off until the unit has drained everything
            if (i == RANDOM_ITEMS / 2) begin
                @(negedge i_clk);
                s_valid <= 1'b0;
                while (pending_chars.size() != 0) @(posedge i_clk);
            end
            // a stretch with no gaps on either side
            idle_free = (i >= 30 && i < 50);
            case ($urandom_range(0, 3))
                0:       value = {$urandom, $urandom};
                1:       value = 64'($urandom_range(0, 1000));
                2:       value = {$urandom, $urandom} >> $urandom_range(0, 63);
                default: value = {$urandom, $urandom} | 64'h8000_0000;
            endcase
            kind = ($urandom_range(0, 1) == 0) ? KIND_SIGNED : KIND_UNSIGNED;
            if ($urandom_range(0, 6) == 0) begin
                base = BASE_W'($urandom_range(0, 63));
            end else if (kind == KIND_SIGNED && $urandom_range(0, 2) == 0) begin
                base = BASE_DEC;
            end else begin
                base = BASE_W'($urandom_range(2, 36));
            end
            send_request(kind, value, base, "");
        end
        idle_free = 1'b0;
        @(negedge i_clk);
        s_valid <= 1'b0;

        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("converted %0d numbers (%0d from the table), checked %0d characters",
                 numbers_sent, ROW_COUNT, chars_checked);
        $display("signed and unsigned kinds, radix field 0 to 63, decimal negatives");
        if (mismatch_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

@@ integer_to_ascii_radix_unit.f @@
src/iar_pkg.sv
src/iar_ram.sv
src/iar_div.sv
src/integer_to_ascii_radix_unit.sv
tb/tb_top.sv
